@@ rtl/sbl_pkg.sv @@
// Package for the 3x3 stencil mean-blend block: sizes, item structs,
// register indexes and the handshake structs of the divider.
// No dependencies.
package sbl_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int DATA_WIDTH = 32;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 16;
    localparam int OUT_COL_W  = 10;

    localparam int GW_W       = 11;
    localparam int GH_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);

    localparam logic [GW_W-1:0] GRID_WIDTH_RESET  = GW_W'(1024);
    localparam logic [GH_W-1:0] GRID_HEIGHT_RESET = GH_W'(1024);

    // Nine samples need four guard bits.
    localparam int SUM_W     = DATA_WIDTH + 4;
    localparam int DIVR_W    = 4;
    localparam int DIV_RADIX = 6;
    localparam int DIV_CYC   = (SUM_W + DIV_RADIX - 1) / DIV_RADIX;
    localparam int DIV_PAD   = DIV_CYC * DIV_RADIX;

    localparam logic [DIVR_W-1:0] DIVISOR_4 = DIVR_W'(4);
    localparam logic [DIVR_W-1:0] DIVISOR_6 = DIVR_W'(6);
    localparam logic [DIVR_W-1:0] DIVISOR_9 = DIVR_W'(9);

    typedef struct packed {
        logic                         frame_start;
        logic signed [DATA_WIDTH-1:0] source_sample;
        logic signed [DATA_WIDTH-1:0] prior_value;
    } t_in_item;

    typedef struct packed {
        logic [OUT_COL_W-1:0]         out_col;
        logic [ROW_W-1:0]             out_row;
        logic signed [DATA_WIDTH-1:0] out_value;
        logic                         run_last;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

@@ rtl/stencil_3x3_mean_blend.sv @@
// Top level of the 3x3 stencil mean-blend sweep: line-buffer RAM, prior
// delay RAM, 3x3 window, sequencer and output register.
// Depends on sbl_pkg, sbl_ram and sbl_div.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  in      | input     | i_in_valid/o_in_ready  | i_in_item  (t_in_item)
//  out     | output    | o_out_valid/i_out_ready| o_out_item (t_out_item)
//  cfg     | input     | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// An item is accepted, then gets a line-buffer read-modify-write and, for each
// result it causes, window summing, one row per cycle, the 6-bit-per-cycle
// divider and then the blend. The stores need no clearing pass.
// A finished result sits in the output register; the next item is accepted
// while it waits, and a new result stalls in the blend step until it is taken.
// Reset is synchronous, active low; the RAM contents are not cleared.
module stencil_3x3_mean_blend
    import sbl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_SUM   = 6'b000100,
        S_DIVGO = 6'b001000,
        S_DIV   = 6'b010000,
        S_BLEND = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [GW_W-1:0]  r_gw;
    logic [GH_W-1:0]  r_gh;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    logic [COL_W-1:0]             r_i;
    logic [ROW_W-1:0]             r_j;
    logic signed [DATA_WIDTH-1:0] r_src;
    logic signed [DATA_WIDTH-1:0] r_pin;
    logic                         r_i_ge2;
    logic                         r_j_ge2;
    logic [3:0]                   r_emit;
    logic [1:0]                   r_res;
    logic [1:0]                   r_sum_row;
    logic signed [SUM_W-1:0]      r_acc;
    logic signed [DATA_WIDTH-1:0] r_win [9];
    logic                         r_out_valid;
    t_out_item                    r_out_item;

    logic             in_acc;
    logic             out_free;
    logic [COL_W:0]   w_eff;
    logic [ROW_W-1:0] h_eff;
    logic             restart;
    logic [COL_W-1:0] cur_i;
    logic [ROW_W-1:0] cur_j;
    logic             i_last;
    logic             j_last;
    logic [3:0]       emit_mask;

    logic             xc, yc;
    logic [COL_W-1:0] cell_x;
    logic [ROW_W-1:0] cell_y;
    logic [3:0]       emit_left;

    logic signed [DATA_WIDTH-1:0] row_a, row_b, row_c;
    logic                         row_ok;
    logic signed [SUM_W-1:0]      row_sum;

    logic                         ncol3, nrow3;
    logic [DIVR_W-1:0]            divisor;
    logic [SUM_W-1:0]             acc_mag;
    logic signed [SUM_W-1:0]      mean;
    logic signed [SUM_W-1:0]      blend_sum;

    logic [2*DATA_WIDTH-1:0] line_rd_data;
    logic [DATA_WIDTH-1:0]   prior_rd_data;
    logic                    prior_rd_en;

    t_div_req div_req;
    t_div_rsp div_rsp;

    function automatic logic [1:0] first_idx(input logic [3:0] m);
        logic [1:0] idx;
        if (m[0]) begin
            idx = 2'd0;
        end else if (m[1]) begin
            idx = 2'd1;
        end else if (m[2]) begin
            idx = 2'd2;
        end else begin
            idx = 2'd3;
        end
        return idx;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Effective grid size and the raster position of the incoming item.
    always_comb begin
        if (r_gw < GW_W'(2)) begin
            w_eff = (COL_W + 1)'(2);
        end else if (32'(r_gw) > MAX_WIDTH) begin
            w_eff = (COL_W + 1)'(MAX_WIDTH);
        end else begin
            w_eff = (COL_W + 1)'(r_gw);
        end
        h_eff = (r_gh < GH_W'(2)) ? ROW_W'(2) : ROW_W'(r_gh);
    end

    assign restart = i_in_item.frame_start || ({1'b0, r_col} >= w_eff) || (r_row >= h_eff);
    assign cur_i   = restart ? '0 : r_col;
    assign cur_j   = restart ? '0 : r_row;
    assign i_last  = ({1'b0, cur_i} == w_eff - (COL_W + 1)'(1));
    assign j_last  = (cur_j == h_eff - ROW_W'(1));

    // Bit {yc, xc}: yc picks row j-1 or j, xc picks column i-1 or i.
    assign emit_mask[0] = (cur_j != '0) && (cur_i != '0);
    assign emit_mask[1] = (cur_j != '0) && i_last;
    assign emit_mask[2] = j_last && (cur_i != '0);
    assign emit_mask[3] = j_last && i_last;

    assign xc        = r_res[0];
    assign yc        = r_res[1];
    assign cell_x    = xc ? r_i : r_i - COL_W'(1);
    assign cell_y    = yc ? r_j : r_j - ROW_W'(1);
    assign emit_left = r_emit & ~(4'b0001 << r_res);

    // Masked sum of one window row; the leftmost column and the top row drop
    // out at the grid edges and for the cell on the last column or row.
    always_comb begin
        case (r_sum_row)
            2'd0: begin
                row_a = r_win[0];
                row_b = r_win[1];
                row_c = r_win[2];
                row_ok = !yc && r_j_ge2;
            end
            2'd1: begin
                row_a = r_win[3];
                row_b = r_win[4];
                row_c = r_win[5];
                row_ok = 1'b1;
            end
            default: begin
                row_a = r_win[6];
                row_b = r_win[7];
                row_c = r_win[8];
                row_ok = 1'b1;
            end
        endcase
        if (row_ok) begin
            row_sum = SUM_W'(row_b) + SUM_W'(row_c);
            if (!xc && r_i_ge2) begin
                row_sum = row_sum + SUM_W'(row_a);
            end
        end else begin
            row_sum = '0;
        end
    end

    assign ncol3 = !xc && r_i_ge2;
    assign nrow3 = !yc && r_j_ge2;

    always_comb begin
        case ({ncol3, nrow3})
            2'b11:   divisor = DIVISOR_9;
            2'b10:   divisor = DIVISOR_6;
            2'b01:   divisor = DIVISOR_6;
            default: divisor = DIVISOR_4;
        endcase
    end

    assign acc_mag = r_acc[SUM_W-1] ? SUM_W'(-r_acc) : SUM_W'(r_acc);

    assign div_req.start    = (r_state == S_DIVGO);
    assign div_req.dividend = acc_mag;
    assign div_req.divisor  = divisor;

    // Truncation toward zero comes from dividing the magnitude.
    assign mean      = r_acc[SUM_W-1] ? -$signed(div_rsp.quotient) : $signed(div_rsp.quotient);
    assign blend_sum = SUM_W'($signed(prior_rd_data)) + mean;

    assign prior_rd_en = (r_state == S_SUM) && (r_sum_row == 2'd0);

    sbl_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (2 * DATA_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_LOAD),
        .i_wr_addr (r_i),
        .i_wr_data ({line_rd_data[DATA_WIDTH-1:0], r_src}),
        .i_rd_en   (in_acc),
        .i_rd_addr (cur_i),
        .o_rd_data (line_rd_data)
    );

    sbl_ram #(
        .DEPTH (2 * MAX_WIDTH),
        .WIDTH (DATA_WIDTH)
    ) u_prior_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_LOAD),
        .i_wr_addr ({r_j[0], r_i}),
        .i_wr_data (r_pin),
        .i_rd_en   (prior_rd_en),
        .i_rd_addr ({cell_y[0], cell_x}),
        .o_rd_data (prior_rd_data)
    );

    sbl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = (r_emit == 4'b0000) ? S_IDLE : S_SUM;
            end
            S_SUM: begin
                if (r_sum_row == 2'd2) begin
                    n_state = S_DIVGO;
                end
            end
            S_DIVGO: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_BLEND;
                end
            end
            S_BLEND: begin
                if (out_free) begin
                    n_state = (emit_left == 4'b0000) ? S_IDLE : S_SUM;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gw        <= GRID_WIDTH_RESET;
            r_gh        <= GRID_HEIGHT_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_GRID_WIDTH:  r_gw <= i_cfg_data[GW_W-1:0];
                    REG_GRID_HEIGHT: r_gh <= i_cfg_data[GH_W-1:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                if (i_last) begin
                    r_col <= '0;
                    r_row <= j_last ? '0 : cur_j + ROW_W'(1);
                end else begin
                    r_col <= cur_i + COL_W'(1);
                    r_row <= cur_j;
                end
            end
            if (r_state == S_BLEND && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item and window datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_i     <= cur_i;
                    r_j     <= cur_j;
                    r_src   <= i_in_item.source_sample;
                    r_pin   <= i_in_item.prior_value;
                    r_i_ge2 <= (cur_i >= COL_W'(2));
                    r_j_ge2 <= (cur_j >= ROW_W'(2));
                    r_emit  <= emit_mask;
                end
            end
            S_LOAD: begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r*3]     <= r_win[r*3 + 1];
                    r_win[r*3 + 1] <= r_win[r*3 + 2];
                end
                r_win[2]  <= $signed(line_rd_data[2*DATA_WIDTH-1:DATA_WIDTH]);
                r_win[5]  <= $signed(line_rd_data[DATA_WIDTH-1:0]);
                r_win[8]  <= r_src;
                r_res     <= first_idx(r_emit);
                r_sum_row <= 2'd0;
                r_acc     <= '0;
            end
            S_SUM: begin
                r_acc     <= r_acc + row_sum;
                r_sum_row <= r_sum_row + 2'd1;
            end
            S_BLEND: begin
                if (out_free) begin
                    r_out_item.out_col   <= OUT_COL_W'(cell_x);
                    r_out_item.out_row   <= cell_y;
                    r_out_item.out_value <= DATA_WIDTH'(blend_sum >>> 1);
                    r_out_item.run_last  <= (emit_left == 4'b0000);
                    r_emit    <= emit_left;
                    r_res     <= first_idx(emit_left);
                    r_sum_row <= 2'd0;
                    r_acc     <= '0;
                end
            end
            default: ;
        endcase
    end

endmodule

@@ rtl/sbl_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and holds until the next read. No dependencies.
module sbl_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/sbl_div.sv @@
// Iterative unsigned divider by a small divisor (4, 6 or 9), several
// quotient bits per cycle, MSB first. Depends on sbl_pkg.
module sbl_div
    import sbl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int STEP_W = $clog2(DIV_CYC + 1);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [DIV_PAD-1:0]  r_num;
    logic [DIV_PAD-1:0]  r_quo;
    logic [DIVR_W-1:0]   r_rem;
    logic [DIVR_W-1:0]   r_div;

    logic [DIV_PAD-1:0]  n_quo;
    logic [DIVR_W-1:0]   n_rem;
    logic [DIVR_W:0]     trial;

    // The remainder stays below the divisor, so each step is a 5-bit compare.
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        trial = '0;
        for (int k = 0; k < DIV_RADIX; k++) begin
            trial = {n_rem, r_num[DIV_PAD-1-k]};
            if (trial >= {1'b0, r_div}) begin
                trial = trial - {1'b0, r_div};
                n_quo = {n_quo[DIV_PAD-2:0], 1'b1};
            end else begin
                n_quo = {n_quo[DIV_PAD-2:0], 1'b0};
            end
            n_rem = trial[DIVR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_CYC - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= DIV_PAD'(i_req.dividend);
            r_quo <= '0;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_num <= r_num << DIV_RADIX;
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo[SUM_W-1:0];

endmodule

@@ test/stencil_3x3_mean_blend_tb.sv @@
// Self-checking testbench for stencil_3x3_mean_blend: raster sweeps over small and extreme grids,
// predicted cell by cell and compared with every result item. Depends on sbl_pkg and the block.
module stencil_3x3_mean_blend_tb;
    import sbl_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int SETTLE_CYCLES = 60;
    localparam int RANDOM_ITEMS  = 80;
    localparam int WIDE_ITEMS    = 24;

    // Indexes that decode to no register.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

    localparam logic signed [DATA_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    localparam int DRAIN_FULL    = 0;
    localparam int DRAIN_RANDOM  = 1;
    localparam int DRAIN_PATTERN = 2;
    localparam int DRAIN_SLOW    = 3;
    localparam logic [6:0] READY_PATTERN = 7'b1011001;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in_item              in_item;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predictor state: registers, line stores, prior history, window and position.
    logic [GW_W-1:0]            grid_w_reg;
    logic [GH_W-1:0]            grid_h_reg;
    bit signed [DATA_WIDTH-1:0] line_above [MAX_WIDTH];
    bit signed [DATA_WIDTH-1:0] line_mid [MAX_WIDTH];
    bit signed [DATA_WIDTH-1:0] prior_hist [2*MAX_WIDTH];
    bit signed [DATA_WIDTH-1:0] window [9];
    int                         sweep_col = 0;
    int                         sweep_row = 0;
    t_out_item                  pending_cells [$];

    int fail_count    = 0;
    int cycle_count   = 0;
    int hold_off_left = 0;
    int drain_mode    = DRAIN_FULL;
    int drain_phase   = 0;
    int burst_left    = 0;
    bit gaps_on       = 1'b0;

    stencil_3x3_mean_blend uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    function automatic int eff_width();
        if (grid_w_reg < 2) return 2;
        if (grid_w_reg > MAX_WIDTH) return MAX_WIDTH;
        return int'(grid_w_reg);
    endfunction

    function automatic int eff_height();
        if (grid_h_reg < 2) return 2;
        return int'(grid_h_reg);
    endfunction

    // Blend of cell (x,y) while the window holds columns i-2..i and rows j-2..j.
    function automatic logic signed [DATA_WIDTH-1:0] cell_blend(input int x, y, i, j, w, h);
        longint total, count, mean, blended;
        int     nx, ny, wc, wr;
        total = 0;
        count = 0;
        for (int dy = -1; dy <= 1; dy++) begin
            for (int dx = -1; dx <= 1; dx++) begin
                nx = x + dx;
                ny = y + dy;
                wc = nx - (i - 2);
                wr = ny - (j - 2);
                if (nx >= 0 && ny >= 0 && nx < w && ny < h &&
                    wc >= 0 && wc <= 2 && wr >= 0 && wr <= 2) begin
                    total += window[wr*3 + wc];
                    count++;
                end
            end
        end
        // Mean truncates toward zero, the blend rounds toward minus infinity.
        mean    = (count > 0) ? total / count : 0;
        blended = longint'(prior_hist[(y % 2)*MAX_WIDTH + x]) + mean;
        blended = blended >>> 1;
        return blended[DATA_WIDTH-1:0];
    endfunction

    // Moves the sweep on by one accepted item and queues the cells it completes.
    task automatic advance_sweep(input t_in_item it);
        int        w, h, i, j, ny, nx;
        int        ys [2];
        int        xs [2];
        t_out_item res_item;
        w = eff_width();
        h = eff_height();
        i = sweep_col;
        j = sweep_row;
        if (it.frame_start || i >= w || j >= h) begin
            i = 0;
            j = 0;
        end
        for (int r = 0; r < 3; r++) begin
            window[r*3]     = window[r*3 + 1];
            window[r*3 + 1] = window[r*3 + 2];
        end
        window[2]     = line_above[i];
        window[5]     = line_mid[i];
        window[8]     = it.source_sample;
        line_above[i] = line_mid[i];
        line_mid[i]   = it.source_sample;
        prior_hist[(j % 2)*MAX_WIDTH + i] = it.prior_value;

        ny = 0;
        nx = 0;
        if (j >= 1) begin
            ys[ny] = j - 1;
            ny++;
        end
        if (j == h - 1) begin
            ys[ny] = j;
            ny++;
        end
        if (i >= 1) begin
            xs[nx] = i - 1;
            nx++;
        end
        if (i == w - 1) begin
            xs[nx] = i;
            nx++;
        end
        for (int a = 0; a < ny; a++) begin
            for (int b = 0; b < nx; b++) begin
                res_item.out_col   = OUT_COL_W'(xs[b]);
                res_item.out_row   = ROW_W'(ys[a]);
                res_item.out_value = cell_blend(xs[b], ys[a], i, j, w, h);
                res_item.run_last  = (a == ny - 1 && b == nx - 1);
                pending_cells.push_back(res_item);
            end
        end

        i++;
        if (i >= w) begin
            i = 0;
            j++;
            if (j >= h) j = 0;
        end
        sweep_col = i;
        sweep_row = j;
    endtask

    function automatic t_in_item make_item(input logic restart,
                                           input logic signed [DATA_WIDTH-1:0] src, prior);
        t_in_item it;
        it.frame_start   = restart;
        it.source_sample = src;
        it.prior_value   = prior;
        return it;
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3:    return DATA_WIDTH'($urandom_range(0, 2000)) - DATA_WIDTH'(1000);
            default: return DATA_WIDTH'($urandom);
        endcase
    endfunction

    // Offers one item, in bursts with random gaps when gaps are on.
    task automatic send_cell(input t_in_item it);
        int gap;
        gap = 0;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            if (gaps_on)
                gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        advance_sweep(it);
    endtask

    task automatic send_run(input int count, input bit restart);
        for (int k = 0; k < count; k++)
            send_cell(make_item(restart && k == 0, pick_sample(), pick_sample()));
    endtask

    // Stops offering, waits for every queued cell and lets the last item finish.
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_GRID_WIDTH) grid_w_reg = data[GW_W-1:0];
        else if (idx == REG_GRID_HEIGHT) grid_h_reg = data[GH_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_corner_values();
        write_reg(REG_GRID_WIDTH, CFG_DATA_W'(3));
        write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(3));
        drain_mode = DRAIN_FULL;
        gaps_on    = 1'b0;
        for (int k = 0; k < 9; k++) send_cell(make_item(k == 0, SAMPLE_MAX, SAMPLE_MAX));
        // The second sweep follows the wrap at the sweep end, with no frame start.
        for (int k = 0; k < 9; k++) send_cell(make_item(1'b0, SAMPLE_MIN, SAMPLE_MIN));
        // Small values of both signs so that truncation and flooring both matter.
        for (int k = 0; k < 9; k++)
            send_cell(make_item(k == 0, (k % 2 != 0) ? -32'sd1 : 32'sd2, -k - 1));
        settle_block();
    endtask

    task automatic test_size_clamps();
        drain_mode = DRAIN_PATTERN;
        gaps_on    = 1'b1;
        // Width and height below two act as two.
        write_reg(REG_GRID_WIDTH, CFG_DATA_W'(0));
        write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(0));
        send_run(4, 1'b1);
        settle_block();
        write_reg(REG_GRID_WIDTH, CFG_DATA_W'(1));
        write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(1));
        send_run(8, 1'b1);
        settle_block();
        // Only eleven bits of width count, and 2047 clamps to the full width.
        write_reg(REG_GRID_WIDTH, 16'hFFFF);
        write_reg(REG_GRID_HEIGHT, 16'hFFFF);
        send_run(6, 1'b1);
        settle_block();
        write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
        // Bit 11 falls off, so this width reads as zero and acts as two.
        write_reg(REG_GRID_WIDTH, 16'h0800);
        send_run(10, 1'b1);
        settle_block();
    endtask

    task automatic test_beyond_grid();
        drain_mode = DRAIN_RANDOM;
        gaps_on    = 1'b1;
        write_reg(REG_GRID_WIDTH, CFG_DATA_W'(8));
        write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(6));
        send_run(20, 1'b1);
        settle_block();
        // The column now lies past the narrower grid, so the next item starts a sweep.
        write_reg(REG_GRID_WIDTH, CFG_DATA_W'(3));
        send_run(9, 1'b0);
        settle_block();
        write_reg(REG_GRID_WIDTH, CFG_DATA_W'(4));
        write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(6));
        send_run(14, 1'b1);
        settle_block();
        write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(3));
        send_run(12, 1'b0);
        settle_block();
    endtask

    // The start of a full-width first row; the column ends far past the next test's grid.
    task automatic test_wide_sweep();
        drain_mode = DRAIN_RANDOM;
        gaps_on    = 1'b1;
        write_reg(REG_GRID_WIDTH, CFG_DATA_W'(MAX_WIDTH));
        write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(2));
        send_run(WIDE_ITEMS, 1'b1);
        settle_block();
    endtask

    task automatic test_backpressure();
        write_reg(REG_GRID_WIDTH, CFG_DATA_W'(5));
        write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(4));
        drain_mode = DRAIN_FULL;
        gaps_on    = 1'b0;
        // The receiver holds off long enough for the block to stall its input.
        hold_off_left = 300;
        send_run(40, 1'b1);
        settle_block();
        drain_mode = DRAIN_SLOW;
        send_run(20, 1'b0);
        settle_block();
    endtask

    task automatic test_random_sweeps();
        int sent, w_data, h_data, n_items, w, h, w_prev, h_prev;
        bit restart, must_restart;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            w_prev = eff_width();
            h_prev = eff_height();
            case ($urandom_range(0, 9))
                0: begin
                    w_data = $urandom_range(0, 1);
                    h_data = $urandom_range(2, 5);
                end
                1: begin
                    w_data = $urandom_range(10, 40);
                    h_data = 2;
                end
                2: begin
                    w_data = $urandom_range(2, 6);
                    h_data = $urandom_range(0, 1);
                end
                default: begin
                    w_data = $urandom_range(2, 9);
                    h_data = $urandom_range(2, 6);
                end
            endcase
            write_reg(REG_GRID_WIDTH, CFG_DATA_W'(w_data));
            write_reg(REG_GRID_HEIGHT, CFG_DATA_W'(h_data));
            w = eff_width();
            h = eff_height();
            // Carrying a half-done sweep into a new shape would read columns never stored.
            must_restart = (w != w_prev || h != h_prev) && (sweep_col != 0 || sweep_row != 0)
                           && sweep_col < w && sweep_row < h;
            drain_mode = $urandom_range(DRAIN_FULL, DRAIN_SLOW);
            gaps_on    = ($urandom_range(0, 3) != 0);
            n_items    = w * h * $urandom_range(1, 2);
            if ($urandom_range(0, 3) == 0) n_items = $urandom_range(1, n_items);
            if (n_items > RANDOM_ITEMS - sent) n_items = RANDOM_ITEMS - sent;
            for (int k = 0; k < n_items; k++) begin
                if (k == 0) restart = must_restart || ($urandom_range(0, 3) != 0);
                else restart = ($urandom_range(0, 39) == 0);
                send_cell(make_item(restart, pick_sample(), pick_sample()));
            end
            sent += n_items;
            settle_block();
        end
    endtask

    // Receiver: a long hold-off when asked, otherwise the current stall pattern.
    always @(negedge clk) begin
        drain_phase++;
        if (hold_off_left > 0) begin
            hold_off_left--;
            out_ready <= 1'b0;
        end else begin
            case (drain_mode)
                DRAIN_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
                DRAIN_PATTERN: out_ready <= READY_PATTERN[drain_phase % 7];
                DRAIN_SLOW:    out_ready <= ($urandom_range(0, 5) == 0);
                default:       out_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk) begin : check_cells
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_cells.size() == 0) begin
                $error("result item with none expected: col %0d row %0d value %0d",
                       out_item.out_col, out_item.out_row, out_item.out_value);
                fail_count++;
            end else begin
                want = pending_cells.pop_front();
                if (out_item.out_col !== want.out_col) begin
                    $error("out_col: expected %0d, got %0d", want.out_col, out_item.out_col);
                    fail_count++;
                end
                if (out_item.out_row !== want.out_row) begin
                    $error("out_row: expected %0d, got %0d", want.out_row, out_item.out_row);
                    fail_count++;
                end
                if (out_item.out_value !== want.out_value) begin
                    $error("out_value: expected %0d, got %0d",
                           want.out_value, out_item.out_value);
                    fail_count++;
                end
                if (out_item.run_last !== want.run_last) begin
                    $error("run_last: expected %0d, got %0d", want.run_last, out_item.run_last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** stencil_3x3_mean_blend: FAILED **");
            $finish;
        end
    end

    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        grid_w_reg = GRID_WIDTH_RESET;
        grid_h_reg = GRID_HEIGHT_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_corner_values();
        test_size_clamps();
        test_beyond_grid();
        test_wide_sweep();
        test_backpressure();
        test_random_sweeps();
        settle_block();

        if (fail_count == 0) $display("** stencil_3x3_mean_blend: PASSED **");
        else $display("** stencil_3x3_mean_blend: FAILED **");
        $finish;
    end

endmodule
